// ===== hdl/pmhg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmhg_pkg
// Types and constants shared by the polar maximum-height grid.
// ----------------------------------------------------------------------------
package pmhg_pkg;

	// one input item: a point to add or a bin to read and clear
	typedef struct packed {
		logic               kind;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic [4:0]         read_ring;
		logic [5:0]         read_sector;
	} item_t;

	// one result item: a bin and its stored height
	typedef struct packed {
		logic [4:0] bin_ring;
		logic [5:0] bin_sector;
		logic [7:0] bin_height;
	} result_t;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam int CORDIC_STEPS = 16;

	// arctangent of 2^-i in 1/65536 of a turn
	function automatic logic [15:0] atan_entry(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0:    r = 16'd8192;
			4'd1:    r = 16'd4836;
			4'd2:    r = 16'd2555;
			4'd3:    r = 16'd1297;
			4'd4:    r = 16'd651;
			4'd5:    r = 16'd326;
			4'd6:    r = 16'd163;
			4'd7:    r = 16'd81;
			4'd8:    r = 16'd41;
			4'd9:    r = 16'd20;
			4'd10:   r = 16'd10;
			4'd11:   r = 16'd5;
			4'd12:   r = 16'd3;
			4'd13:   r = 16'd1;
			4'd14:   r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/pmhg_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmhg_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pmhg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1200
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/polar_max_height_grid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polar_max_height_grid
// Polar grid of rings by sectors holding the maximum scaled point height.
// ----------------------------------------------------------------------------
// One item is worked at a time. A point is squared and scaled (ST_SQ, ST_SUM,
// ST_SCALE), then the 16-step angle CORDIC and the ring search run side by
// side in ST_LOOP, one step a cycle, until both are done (the CORDIC is skipped
// for a point on an axis), then sector, read and write-back states follow. A
// point beyond the range limit is dropped after scaling. A read item takes a
// grid RAM read and then the write-back with the result load, and waits in the
// write-back while the result register holds an untaken result. The next item
// is taken in the cycle after an item ends. After reset a clearing pass writes
// zero to all RING_COUNT*SECTOR_COUNT entries, one a cycle, and no item is
// accepted until it ends.
// ----------------------------------------------------------------------------
module polar_max_height_grid #(
	parameter int RING_COUNT    = 20,
	parameter int SECTOR_COUNT  = 60,
	parameter int RANGE_LIMIT_M = 80
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire pmhg_pkg::item_t  item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output pmhg_pkg::result_t     result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [15:0]      cfg_data
);
	import pmhg_pkg::*;

	localparam int DEPTH  = RING_COUNT * SECTOR_COUNT;
	localparam int AW     = $clog2(DEPTH);
	localparam int RW     = $clog2(RING_COUNT + 1);
	localparam int SW     = $clog2(SECTOR_COUNT + 1);
	localparam int BW     = 44;
	localparam longint LIM = longint'(RANGE_LIMIT_M) * 256;
	localparam logic [BW-1:0] LIM_SQ = BW'(LIM * LIM);
	localparam logic [BW-1:0] RSQ    = BW'(RING_COUNT * RING_COUNT);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_SQ, ST_SUM, ST_SCALE, ST_LOOP, ST_SECT, ST_RD, ST_MOD
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic signed [15:0] offset_q;
	item_t it_q;
	logic [31:0] xx_q, s_q;
	logic signed [16:0] h_q;
	logic [12:0] n_q;
	logic [7:0] hq_q;
	logic [BW-1:0] lhs_q, bsq_q, delta_q;
	logic [RW-1:0] k_q;
	logic ring_done_q, cord_done_q;
	logic signed [35:0] cx_q, cy_q;
	logic [15:0] acc_q;
	logic [3:0] step_q;
	logic [SW-1:0] sector_q;
	logic inrange_q;
	logic result_valid_q;
	result_t result_q;

	logic we, re;
	logic [AW-1:0] waddr, raddr, addr;
	logic [7:0] wdata, rdata;

	pmhg_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_grid (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	// combinational helpers
	logic signed [31:0] yy;
	logic signed [24:0] h255;
	logic [28:0] nmul;
	logic [10:0] qv;
	logic signed [35:0] cx0, cy0, dx, dy;
	logic ring_hit;
	logic [24:0] sect_raw;
	logic [SW-1:0] sect_c;
	logic read_in;
	logic out_free;

	always_comb begin
		yy   = it_q.point_y * it_q.point_y;
		h255 = 25'(h_q) * 25'sd255;
		nmul = 29'(n_q) * 29'd52429;
		qv   = nmul[28:18];
		cx0  = {{4{it_q.point_x[15]}}, it_q.point_x, 16'b0};
		cy0  = {{4{it_q.point_y[15]}}, it_q.point_y, 16'b0};
		if (it_q.point_x[15]) begin
			cx0 = -cx0;
			cy0 = -cy0;
		end
		dx = cy_q >>> step_q;
		dy = cx_q >>> step_q;
		ring_hit = (lhs_q <= bsq_q) || (k_q == RW'(RING_COUNT));
		sect_raw = 25'(acc_q) * 25'(SECTOR_COUNT) + 25'd65535;
		sect_c   = SW'(sect_raw[24:16]);
		if (sect_c < SW'(1)) begin
			sect_c = SW'(1);
		end
		if (sect_c > SW'(SECTOR_COUNT)) begin
			sect_c = SW'(SECTOR_COUNT);
		end
		read_in = (32'(it_q.read_ring) < 32'(RING_COUNT))
			&& (32'(it_q.read_sector) < 32'(SECTOR_COUNT));
		if (it_q.kind == KIND_READ) begin
			addr = AW'(32'(it_q.read_ring) * 32'(SECTOR_COUNT) + 32'(it_q.read_sector));
		end else begin
			addr = AW'(32'(k_q - RW'(1)) * 32'(SECTOR_COUNT) + 32'(sector_q - SW'(1)));
		end
		out_free = !result_valid_q || !result_stall;
	end

	// grid RAM access
	always_comb begin
		re    = (state_q == ST_RD) && ((it_q.kind == KIND_POINT) || read_in);
		raddr = addr;
		we    = 1'b0;
		waddr = addr;
		wdata = 8'd0;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			ST_MOD: begin
				if (it_q.kind == KIND_READ) begin
					we = inrange_q && out_free;
				end else begin
					we    = hq_q > rdata;
					wdata = hq_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer, datapath registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			offset_q       <= 16'sd512;
			result_valid_q <= 1'b0;
			ring_done_q    <= 1'b0;
			cord_done_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				offset_q <= cfg_data;
			end
			// load a read result, drop it once taken
			if ((state_q == ST_MOD) && (it_q.kind == KIND_READ) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						it_q    <= item;
						state_q <= (item.kind == KIND_READ) ? ST_RD : ST_SQ;
					end
				end
				ST_SQ: begin
					xx_q    <= 32'(it_q.point_x * it_q.point_x);
					h_q     <= 17'(it_q.point_z) + 17'(offset_q);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					s_q     <= xx_q + 32'(yy);
					n_q     <= (h_q > 0) ? 13'(h255 >>> 12) : 13'd0;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					lhs_q   <= BW'(s_q) * RSQ;
					hq_q    <= (qv > 11'd255) ? 8'd255 : qv[7:0];
					k_q     <= RW'(1);
					bsq_q   <= LIM_SQ;
					delta_q <= 3 * LIM_SQ;
					step_q  <= '0;
					ring_done_q <= 1'b0;
					cx_q    <= cx0;
					cy_q    <= cy0;
					// exact angles on the axes, else start the CORDIC
					if (it_q.point_y == 16'sd0) begin
						acc_q       <= it_q.point_x[15] ? 16'd32768 : 16'd0;
						cord_done_q <= 1'b1;
					end else if (it_q.point_x == 16'sd0) begin
						acc_q       <= it_q.point_y[15] ? 16'd49152 : 16'd16384;
						cord_done_q <= 1'b1;
					end else begin
						acc_q       <= it_q.point_x[15] ? 16'd32768 : 16'd0;
						cord_done_q <= 1'b0;
					end
					// drop points beyond the range limit
					state_q <= (BW'(s_q) > LIM_SQ) ? ST_IDLE : ST_LOOP;
				end
				ST_LOOP: begin
					if (!cord_done_q) begin
						if (!cy_q[35]) begin
							cx_q  <= cx_q + dx;
							cy_q  <= cy_q - dy;
							acc_q <= acc_q + atan_entry(step_q);
						end else begin
							cx_q  <= cx_q - dx;
							cy_q  <= cy_q + dy;
							acc_q <= acc_q - atan_entry(step_q);
						end
						step_q <= step_q + 4'd1;
						if (step_q == 4'(CORDIC_STEPS - 1)) begin
							cord_done_q <= 1'b1;
						end
					end
					if (!ring_done_q) begin
						if (ring_hit) begin
							ring_done_q <= 1'b1;
						end else begin
							k_q     <= k_q + RW'(1);
							bsq_q   <= bsq_q + delta_q;
							delta_q <= delta_q + (LIM_SQ << 1);
						end
					end
					if (cord_done_q && ring_done_q) begin
						state_q <= ST_SECT;
					end
				end
				ST_SECT: begin
					sector_q <= sect_c;
					state_q  <= ST_RD;
				end
				ST_RD: begin
					inrange_q <= read_in;
					state_q   <= ST_MOD;
				end
				ST_MOD: begin
					if (it_q.kind == KIND_POINT) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						result_q.bin_ring   <= it_q.read_ring;
						result_q.bin_sector <= it_q.read_sector;
						result_q.bin_height <= inrange_q ? rdata : 8'd0;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

endmodule
`default_nettype wire

// ===== hdl/pmhg_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmhg_checker
// Port-level checks of the polar maximum-height grid.
// ----------------------------------------------------------------------------
module pmhg_checker #(
	parameter int RING_COUNT   = 20,
	parameter int SECTOR_COUNT = 60
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_stall,
	input wire pmhg_pkg::item_t   item,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire pmhg_pkg::result_t result
);
	import pmhg_pkg::*;

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// one item at a time: stall right after each transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while busy");

	// bins outside the grid read as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ((32'(result.bin_ring) >= 32'(RING_COUNT))
		|| (32'(result.bin_sector) >= 32'(SECTOR_COUNT))) |-> result.bin_height == 8'd0)
		else $error("out of grid read not zero");

	// a point transfer made while no result is pending raises no result valid
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.kind == KIND_POINT && !result_valid
		|=> !result_valid)
		else $error("result from point item");

endmodule

bind polar_max_height_grid pmhg_checker #(
	.RING_COUNT(RING_COUNT), .SECTOR_COUNT(SECTOR_COUNT)
) u_pmhg_checker (
	.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_stall(item_stall),
	.item(item), .result_valid(result_valid), .result_stall(result_stall),
	.result(result)
);
`default_nettype wire
